// File: rtl/mbx_pkg.sv
// mbx_pkg: shared types for the message slot mailbox
`timescale 1ns / 1ps

package mbx_pkg;

    // one input word
    typedef struct packed {
        logic        action;
        logic [15:0] src_id;
        logic [15:0] dst_id;
        logic [6:0]  size;
        logic [7:0]  data_byte;
        logic        last;
    } t_in;

    // one result word
    typedef struct packed {
        logic        status;
        logic [15:0] src_id_res;
        logic [15:0] dst_id_res;
        logic [6:0]  size_res;
        logic [7:0]  data_byte_res;
        logic        last_res;
    } t_res;

    // slot header as held in the header memory
    typedef struct packed {
        logic [15:0] sender;
        logic [15:0] target;
        logic [6:0]  length;
    } t_hdr;

    // action codes
    localparam logic ACT_SEND = 1'b0;
    localparam logic ACT_RECV = 1'b1;

    // status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    localparam logic [6:0] COUNT_MAX = 7'd127;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_SCAN,
        S_MATCH_RD,
        S_MATCH_CMP,
        S_STREAM
    } t_state;

endpackage

// File: rtl/mbx_ram.sv
// mbx_ram: generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module mbx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/message_slot_mailbox_top.sv
// message_slot_mailbox_top: slot mailbox with scan sequencer and payload memory
// send bytes after the first: accepted in S_IDLE, status word for the last byte the next cycle
// first send byte: free-slot scan over up to SLOT_COUNT slots, one slot a cycle
// receive: each slot compared by a header memory read state then a compare state, then one byte a cycle
// the receiver cannot stall; every result word stands for one cycle with o_strobe
// synchronous active-low reset clears slot valid bits and the sequencer; memories keep contents
`timescale 1ns / 1ps

module message_slot_mailbox_top #(
    parameter int SLOT_COUNT  = 8,
    parameter int MAX_PAYLOAD = 64,
    parameter int PID_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  mbx_pkg::t_in  i_item,
    output logic        o_strobe,
    output mbx_pkg::t_res o_result
);
    import mbx_pkg::*;

    localparam int SLOT_W    = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
    localparam int PAY_AW    = MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1;
    localparam int PAY_DEPTH = SLOT_COUNT << PAY_AW;
    localparam int PAY_RW    = PAY_DEPTH > 1 ? $clog2(PAY_DEPTH) : 1;
    localparam int HDR_RW    = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
    localparam logic [15:0] PID_MASK =
        PID_BITS >= 16 ? 16'hFFFF : 16'((32'd1 << PID_BITS) - 32'd1);
    localparam logic [6:0] MAX_LEN   = 7'(MAX_PAYLOAD);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    // state
    t_state                r_state, n_state;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic                  r_busy, n_busy;
    logic                  r_failed, n_failed;
    logic [6:0]            r_count, n_count;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [6:0]            r_len, n_len;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [6:0]            r_j, n_j;
    t_in                   r_item, n_item;
    t_hdr                  r_rx, n_rx;
    logic                  r_strobe, n_strobe;
    t_res                  r_res, n_res;
    logic                  r_res_ram, n_res_ram;

    // memory ports
    logic                  pay_we;
    logic [SLOT_W+PAY_AW-1:0] pay_waddr_full, pay_raddr_full;
    logic [7:0]            pay_wdata, pay_rdata;
    logic                  hdr_we;
    t_hdr                  hdr_wdata, hdr_rdata;

    // masked ids of the held word and of the input word
    logic [15:0] snd_m, tgt_m, in_snd_m, in_tgt_m;
    logic        accept;
    logic [6:0]  count_inc;
    logic        cmp_hit;

    assign in_snd_m  = i_item.src_id & PID_MASK;
    assign in_tgt_m  = i_item.dst_id & PID_MASK;
    assign snd_m     = r_item.src_id & PID_MASK;
    assign tgt_m     = r_item.dst_id & PID_MASK;
    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 7'd1;

    // shared compare unit: free test while scanning for a slot, target match otherwise
    always_comb begin
        if (r_state == S_FREE_SCAN) begin
            cmp_hit = !r_valid[r_idx];
        end else begin
            cmp_hit = r_valid[r_idx] && (hdr_rdata.target == tgt_m);
        end
    end

    // sequencer and datapath next state
    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_busy    = r_busy;
        n_failed  = r_failed;
        n_count   = r_count;
        n_slot    = r_slot;
        n_len     = r_len;
        n_idx     = r_idx;
        n_j       = r_j;
        n_item    = r_item;
        n_rx      = r_rx;
        n_strobe  = 1'b0;
        n_res     = '0;
        n_res_ram = 1'b0;
        pay_we    = 1'b0;
        pay_waddr_full = {r_slot, r_count[PAY_AW-1:0]};
        pay_wdata = i_item.data_byte;
        hdr_we    = 1'b0;
        hdr_wdata = '{sender: snd_m, target: tgt_m, length: r_item.size};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item = i_item;
                    if (i_item.action == ACT_RECV) begin
                        if (in_tgt_m == 16'd0) begin
                            n_strobe         = 1'b1;
                            n_res.status     = ST_FAIL;
                            n_res.last_res   = 1'b1;
                        end else begin
                            n_idx   = '0;
                            n_state = S_MATCH_RD;
                        end
                    end else if (r_busy) begin
                        // later byte of a running send
                        if (!r_failed && r_count < r_len) begin
                            pay_we = 1'b1;
                        end
                        n_count = count_inc;
                        if (i_item.last) begin
                            n_strobe       = 1'b1;
                            n_res.last_res = 1'b1;
                            if (!r_failed && count_inc == r_len) begin
                                n_valid[r_slot] = 1'b1;
                                n_res.status    = ST_OK;
                            end else begin
                                n_res.status    = ST_FAIL;
                            end
                            n_busy   = 1'b0;
                            n_failed = 1'b0;
                            n_count  = '0;
                        end
                    end else if (in_snd_m == 16'd0 || in_tgt_m == 16'd0 ||
                                 i_item.size == 7'd0 || i_item.size > MAX_LEN) begin
                        // rejected header
                        if (i_item.last) begin
                            n_strobe       = 1'b1;
                            n_res.status   = ST_FAIL;
                            n_res.last_res = 1'b1;
                        end else begin
                            n_busy   = 1'b1;
                            n_failed = 1'b1;
                            n_count  = 7'd1;
                        end
                    end else begin
                        n_idx   = '0;
                        n_state = S_FREE_SCAN;
                    end
                end
            end

            S_FREE_SCAN: begin
                if (cmp_hit) begin
                    // reserve slot and store the first byte
                    hdr_we         = 1'b1;
                    pay_we         = 1'b1;
                    pay_waddr_full = {r_idx, {PAY_AW{1'b0}}};
                    pay_wdata      = r_item.data_byte;
                    n_slot         = r_idx;
                    n_len          = r_item.size;
                    n_failed       = 1'b0;
                    n_state        = S_IDLE;
                    if (r_item.last) begin
                        n_strobe       = 1'b1;
                        n_res.last_res = 1'b1;
                        if (r_item.size == 7'd1) begin
                            n_valid[r_idx] = 1'b1;
                            n_res.status   = ST_OK;
                        end else begin
                            n_res.status   = ST_FAIL;
                        end
                        n_busy  = 1'b0;
                        n_count = '0;
                    end else begin
                        n_busy  = 1'b1;
                        n_count = 7'd1;
                    end
                end else if (r_idx == LAST_SLOT) begin
                    // no free slot
                    n_state = S_IDLE;
                    if (r_item.last) begin
                        n_strobe       = 1'b1;
                        n_res.status   = ST_FAIL;
                        n_res.last_res = 1'b1;
                        n_busy         = 1'b0;
                        n_failed       = 1'b0;
                        n_count        = '0;
                    end else begin
                        n_busy   = 1'b1;
                        n_failed = 1'b1;
                        n_count  = 7'd1;
                    end
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end

            S_MATCH_RD: begin
                n_state = S_MATCH_CMP;
            end

            S_MATCH_CMP: begin
                if (cmp_hit) begin
                    n_rx    = hdr_rdata;
                    n_j     = '0;
                    n_state = S_STREAM;
                end else if (r_idx == LAST_SLOT) begin
                    n_strobe       = 1'b1;
                    n_res.status   = ST_FAIL;
                    n_res.last_res = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_idx   = r_idx + SLOT_W'(1);
                    n_state = S_MATCH_RD;
                end
            end

            S_STREAM: begin
                // issue one payload read a cycle, data joins the word in the next cycle
                n_strobe             = 1'b1;
                n_res_ram            = 1'b1;
                n_res.status         = ST_OK;
                n_res.src_id_res     = r_rx.sender;
                n_res.dst_id_res     = r_rx.target;
                n_res.size_res       = r_rx.length;
                n_res.last_res       = (r_j + 7'd1 == r_rx.length);
                n_j                  = r_j + 7'd1;
                if (r_j + 7'd1 == r_rx.length) begin
                    n_valid[r_idx] = 1'b0;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign pay_raddr_full = {r_idx, r_j[PAY_AW-1:0]};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_busy   <= 1'b0;
            r_failed <= 1'b0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_busy   <= n_busy;
            r_failed <= n_failed;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_slot    <= n_slot;
        r_len     <= n_len;
        r_idx     <= n_idx;
        r_j       <= n_j;
        r_item    <= n_item;
        r_rx      <= n_rx;
        r_res     <= n_res;
        r_res_ram <= n_res_ram;
    end

    // result word, payload byte straight from the ram output register
    always_comb begin
        o_result = r_res;
        if (r_res_ram) begin
            o_result.data_byte_res = pay_rdata;
        end
    end
    assign o_strobe = r_strobe;

    // slot headers
    mbx_ram #(
        .WIDTH ($bits(t_hdr)),
        .DEPTH (SLOT_COUNT)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (hdr_we),
        .i_waddr (r_idx[HDR_RW-1:0]),
        .i_wdata (hdr_wdata),
        .i_raddr (r_idx[HDR_RW-1:0]),
        .o_rdata (hdr_rdata)
    );

    // payload bytes, one row of 2**PAY_AW per slot
    mbx_ram #(
        .WIDTH (8),
        .DEPTH (PAY_DEPTH)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (pay_waddr_full[PAY_RW-1:0]),
        .i_wdata (pay_wdata),
        .i_raddr (pay_raddr_full[PAY_RW-1:0]),
        .o_rdata (pay_rdata)
    );
endmodule
